/* src/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam logic [20:0] REPL_CHAR  = 21'h00fffd;
	localparam logic [20:0] MIN_LEN2   = 21'h000080;
	localparam logic [20:0] MIN_LEN3   = 21'h000800;
	localparam logic [20:0] SURR_LO    = 21'h00d800;
	localparam logic [20:0] SURR_HI    = 21'h00dfff;
	localparam logic [20:0] MIN_LEN4   = 21'h010000;
	localparam logic [20:0] MAX_SCALAR = 21'h10ffff;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// one queue entry: a run of replacements, then an optional decoded value
	typedef struct packed {
		logic [2:0]  nrep;
		logic        tail_vld;
		logic [20:0] tail_cp;
		logic [2:0]  tail_used;
		logic        eos;
	} entry_t;

	function automatic logic value_ok(input logic [20:0] cp, input logic [2:0] len);
		logic ok;
		begin
			ok = 1'b0;
			if (len == LEN_TWO)
				ok = (cp >= MIN_LEN2);
			else if (len == LEN_THREE)
				ok = (cp >= MIN_LEN3) && !((cp >= SURR_LO) && (cp <= SURR_HI));
			else
				ok = (cp >= MIN_LEN4) && (cp <= MAX_SCALAR);
			return ok;
		end
	endfunction

endpackage

/* src/u8d_front.sv */
// ----------------------------------------------------------------------------
// u8d_front
// Byte classifier: holds the open sequence and turns each byte into an entry.
// ----------------------------------------------------------------------------
module u8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              end_of_stream,
	output logic              push,
	output u8d_pkg::entry_t   entry
);

	logic [20:0] partial_q;
	logic [2:0]  len_q;
	logic [1:0]  seen_q;

	logic [20:0] partial_n;
	logic [2:0]  len_n;
	logic [1:0]  seen_n;
	logic [2:0]  seen_inc;
	logic [20:0] cp_ext;
	logic        as_lead;
	u8d_pkg::entry_t ent;

	always_comb begin
		partial_n = partial_q;
		len_n     = len_q;
		seen_n    = seen_q;
		as_lead   = 1'b1;
		seen_inc  = {1'b0, seen_q} + 3'd1;
		cp_ext    = {partial_q[14:0], data_byte[5:0]};
		ent.nrep      = 3'd0;
		ent.tail_vld  = 1'b0;
		ent.tail_cp   = {13'd0, data_byte};
		ent.tail_used = u8d_pkg::LEN_ONE;
		ent.eos       = end_of_stream;

		if (len_q != u8d_pkg::LEN_NONE) begin
			if (data_byte[7:6] == 2'b10) begin
				as_lead = 1'b0;
				if (seen_inc == len_q) begin
					if (u8d_pkg::value_ok(cp_ext, len_q)) begin
						ent.tail_vld  = 1'b1;
						ent.tail_cp   = cp_ext;
						ent.tail_used = len_q;
					end else begin
						ent.nrep = len_q;
					end
					partial_n = '0;
					len_n     = u8d_pkg::LEN_NONE;
					seen_n    = 2'd0;
				end else begin
					partial_n = cp_ext;
					seen_n    = seen_inc[1:0];
				end
			end else begin
				// broken sequence: one replacement per byte collected
				ent.nrep  = {1'b0, seen_q};
				partial_n = '0;
				len_n     = u8d_pkg::LEN_NONE;
				seen_n    = 2'd0;
			end
		end

		if (as_lead) begin
			if (data_byte[7] == 1'b0) begin
				ent.tail_vld = 1'b1;
			end else if (data_byte[7:5] == 3'b110) begin
				partial_n = {16'd0, data_byte[4:0]};
				len_n     = u8d_pkg::LEN_TWO;
				seen_n    = 2'd1;
			end else if (data_byte[7:4] == 4'b1110) begin
				partial_n = {17'd0, data_byte[3:0]};
				len_n     = u8d_pkg::LEN_THREE;
				seen_n    = 2'd1;
			end else if (data_byte[7:3] == 5'b11110) begin
				partial_n = {18'd0, data_byte[2:0]};
				len_n     = u8d_pkg::LEN_FOUR;
				seen_n    = 2'd1;
			end else begin
				ent.nrep = ent.nrep + 3'd1;
			end
		end

		// stream end flushes whatever is still open
		if (end_of_stream && (len_n != u8d_pkg::LEN_NONE)) begin
			ent.nrep  = ent.nrep + {1'b0, seen_n};
			partial_n = '0;
			len_n     = u8d_pkg::LEN_NONE;
			seen_n    = 2'd0;
		end
	end

	assign entry = ent;
	assign push  = accept && ((ent.nrep != 3'd0) || ent.tail_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			len_q     <= u8d_pkg::LEN_NONE;
			seen_q    <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_n;
			len_q     <= len_n;
			seen_q    <= seen_n;
		end
	end

endmodule

/* src/u8d_queue.sv */
// ----------------------------------------------------------------------------
// u8d_queue
// Small entry queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module u8d_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8d_pkg::entry_t   wr_entry,
	input  logic              pop,
	output u8d_pkg::entry_t   head,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8d_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* src/u8d_back.sv */
// ----------------------------------------------------------------------------
// u8d_back
// Result sequencer: expands one entry into its results behind an output register.
// ----------------------------------------------------------------------------
module u8d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  u8d_pkg::entry_t   head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [20:0]       code_point,
	output logic              replaced,
	output logic [2:0]        bytes_used,
	output logic              last_of_run,
	output logic              stream_done
);

	logic [1:0]  idx_q;
	logic        ovld_q;
	logic [20:0] cp_q;
	logic        rep_q;
	logic [2:0]  used_q;
	logic        last_q;
	logic        done_q;

	logic [2:0]  total;
	logic        is_last;
	logic        is_tail;
	logic        advance;

	assign total   = head.nrep + {2'd0, head.tail_vld};
	assign is_last = ({1'b0, idx_q} == (total - 3'd1));
	assign is_tail = head.tail_vld && is_last;
	assign advance = !empty && (!ovld_q || out_ready);
	assign pop     = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			ovld_q <= 1'b0;
		end else begin
			if (advance)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (advance)
				ovld_q <= 1'b1;
			else if (out_ready)
				ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cp_q   <= is_tail ? head.tail_cp : u8d_pkg::REPL_CHAR;
			rep_q  <= !is_tail;
			used_q <= is_tail ? head.tail_used : u8d_pkg::LEN_ONE;
			last_q <= is_last;
			done_q <= is_last && head.eos;
		end
	end

	assign out_valid   = ovld_q;
	assign code_point  = cp_q;
	assign replaced    = rep_q;
	assign bytes_used  = used_q;
	assign last_of_run = last_q;
	assign stream_done = done_q;

endmodule

/* src/utf8_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// UTF-8 byte stream to code point decoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Input stream: one raw byte per transaction on s_axis_tdata, s_axis_tlast on
// the final byte of a stream. Output stream: one code point per transaction,
// with a replacement flag and byte count in m_axis_tdata, m_axis_tlast on the
// last result caused by an input byte and m_axis_tuser on the last result of
// a stream.
// Each byte is classified in the cycle it is accepted and, if it yields any
// results, written to a queue of QUEUE_DEPTH entries; its first result passes
// from the queue into the output register. The result sequencer emits one
// result per cycle while the output is not stalled; a byte yields 0..4 results.
// The sustained input rate is one byte per cycle while the result count stays
// at or below one without an output stall; the queue absorbs short error runs.
// A stall on the output holds the output register; bytes keep being accepted
// until the queue fills, then s_axis_tready drops.
// Reset clears the open sequence, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [20:0] code_point, [21] replaced, [24:22] bytes_used
	output logic        m_axis_tlast,   // last_of_run
	output logic        m_axis_tuser    // stream_done
);

	u8d_pkg::entry_t new_entry;
	u8d_pkg::entry_t head_entry;
	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	logic [20:0]     code_point;
	logic            replaced;
	logic [2:0]      bytes_used;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	u8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_axis_tdata),
		.end_of_stream (s_axis_tlast),
		.push          (push),
		.entry         (new_entry)
	);

	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (new_entry),
		.pop      (pop),
		.head     (head_entry),
		.full     (full),
		.empty    (empty)
	);

	u8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_entry),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.code_point  (code_point),
		.replaced    (replaced),
		.bytes_used  (bytes_used),
		.last_of_run (m_axis_tlast),
		.stream_done (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, bytes_used, replaced, code_point};

`ifndef SYNTHESIS
	// every stream end produces at least one result
	a_eos_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |-> push)
		else $error("stream end produced no queue entry");

	// stream_done only on the last result of a byte
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("stream_done without last_of_run");

	// replacements always carry U+FFFD and one byte
	a_repl_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && replaced |-> (code_point == u8d_pkg::REPL_CHAR) &&
			(bytes_used == u8d_pkg::LEN_ONE))
		else $error("replacement with wrong value");

	// an entry is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
`endif

endmodule
